/* sv/tmeb_pkg.sv */
// tmeb_pkg.sv: shared types and codes of the tag match extract buffer
`timescale 1ns / 1ps

package tmeb_pkg;

   localparam int TAG_BITS    = 8;
   localparam int STATUS_BITS = 2;
   localparam int KIND_BITS   = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int MAX_RESULTS = 16;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // tag kind codes
   localparam logic [KIND_BITS-1:0] KIND_RECEIVER    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRANSMITTER = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TARGET      = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE_FOUND = 2'd2;

   typedef struct packed {
      logic [TAG_BITS-1:0] receiver;
      logic [TAG_BITS-1:0] transmitter;
      logic [TAG_BITS-1:0] target;
   } tags_type;

   localparam int TAGS_BITS = $bits(tags_type);

   function automatic logic tag_match(tags_type t, logic [KIND_BITS-1:0] kind,
                                      logic [TAG_BITS-1:0] value);
      logic hit;
      case (kind)
         KIND_RECEIVER:    hit = (t.receiver == value);
         KIND_TRANSMITTER: hit = (t.transmitter == value);
         KIND_TARGET:      hit = (t.target == value);
         default:          hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* sv/tag_match_extract_buffer_top.sv */
// tag_match_extract_buffer_top.sv: ordered tagged entry store with pop by tag
`timescale 1ns / 1ps

// Usage: an item is taken when start is high and busy is low. req_cmd picks an
// insert (append one entry at the young end) or a pop (remove every entry whose
// tag of kind req_tag_kind equals req_tag_value, oldest first).
// Results come on the rsp_ ports for one cycle each, marked by rsp_valid; the
// receiver cannot stall them, so each result must be taken as it appears.
// An insert gives one result (ok or full) in the cycle after it is taken and
// leaves busy low, so inserts can follow back to back.
// A pop walks the entry memory one entry a cycle through its single read port
// and writes kept entries back compacted: it stays busy until the scan is done and
// gives one result per removed entry (up to 16) or a single none found result.
// Results of a pop trail the scan by one entry, so the final one can carry
// rsp_last_of_run. A pop of an empty store answers in the next cycle.
// Reset empties the store at once (only the entry count is cleared); no item is
// in flight after reset.
module tag_match_extract_buffer_top #(
   parameter int STORE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic [tmeb_pkg::KIND_BITS-1:0]         req_tag_kind,
   input  logic [tmeb_pkg::TAG_BITS-1:0]          req_tag_value,
   input  logic [tmeb_pkg::TAG_BITS-1:0]          req_entry_receiver,
   input  logic [tmeb_pkg::TAG_BITS-1:0]          req_entry_transmitter,
   input  logic [tmeb_pkg::TAG_BITS-1:0]          req_entry_target,
   input  logic [PAYLOAD_BITS-1:0]                req_entry_payload,
   output logic                                   rsp_valid,
   output logic [tmeb_pkg::STATUS_BITS-1:0]       rsp_result_status,
   output logic [tmeb_pkg::TAG_BITS-1:0]          rsp_out_receiver,
   output logic [tmeb_pkg::TAG_BITS-1:0]          rsp_out_transmitter,
   output logic [tmeb_pkg::TAG_BITS-1:0]          rsp_out_target,
   output logic [PAYLOAD_BITS-1:0]                rsp_out_payload,
   output logic                                   rsp_last_of_run,
   output logic [tmeb_pkg::COUNT_OUT_BITS-1:0]    rsp_stored_count
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int TW = (CW > tmeb_pkg::COUNT_OUT_BITS) ? CW : tmeb_pkg::COUNT_OUT_BITS;
   localparam int WW = tmeb_pkg::TAGS_BITS + PAYLOAD_BITS;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [TW-1:0] taken_ff, taken_in;
   logic          chk_valid_ff, chk_valid_in;
   logic          held_valid_ff, held_valid_in;
   logic [WW-1:0] held_ff, held_in;
   logic [tmeb_pkg::KIND_BITS-1:0] kind_ff, kind_in;
   logic [tmeb_pkg::TAG_BITS-1:0]  tag_ff, tag_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tmeb_pkg::STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [WW-1:0]                       rsp_entry_ff, rsp_entry_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic [tmeb_pkg::COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // entry memory, one write and one registered read port
   logic [WW-1:0] entry_mem [STORE_DEPTH];
   logic [WW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;

   tmeb_pkg::tags_type rd_tags;
   logic               rd_hit;
   logic [TW-1:0]      remain;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_addr = issue_ff[AW-1:0];
   assign rd_tags = tmeb_pkg::tags_type'(rd_data_ff[PAYLOAD_BITS +: tmeb_pkg::TAGS_BITS]);
   assign rd_hit  = tmeb_pkg::tag_match(rd_tags, kind_ff, tag_ff)
                    && (taken_ff < TW'(tmeb_pkg::MAX_RESULTS));
   assign remain  = TW'(count_ff) - taken_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      keep_in       = keep_ff;
      taken_in      = taken_ff;
      chk_valid_in  = 1'b0;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      kind_in       = kind_ff;
      tag_in        = tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata     = {req_entry_receiver, req_entry_transmitter, req_entry_target,
                       req_entry_payload};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == tmeb_pkg::CMD_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = '0;
                  rsp_last_in  = 1'b1;
                  if (count_ff >= CW'(STORE_DEPTH)) begin
                     rsp_status_in = tmeb_pkg::STATUS_FULL;
                     rsp_count_in  = tmeb_pkg::COUNT_OUT_BITS'(TW'(count_ff));
                  end else begin
                     mem_we        = 1'b1;
                     count_in      = count_ff + 1'b1;
                     rsp_status_in = tmeb_pkg::STATUS_OK;
                     rsp_count_in  = tmeb_pkg::COUNT_OUT_BITS'(TW'(count_ff) + 1'b1);
                  end
               end else begin
                  kind_in = req_tag_kind;
                  tag_in  = req_tag_value;
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = tmeb_pkg::STATUS_NONE_FOUND;
                     rsp_entry_in  = '0;
                     rsp_last_in   = 1'b1;
                     rsp_count_in  = '0;
                  end else begin
                     state_in      = ST_SCAN;
                     issue_in      = '0;
                     keep_in       = '0;
                     taken_in      = '0;
                     held_valid_in = 1'b0;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               chk_valid_in = 1'b1;
               issue_in     = issue_ff + 1'b1;
            end
            if (chk_valid_ff) begin
               if (rd_hit) begin
                  // hand out the previous match, it is not the final one
                  if (held_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = tmeb_pkg::STATUS_OK;
                     rsp_entry_in  = held_ff;
                     rsp_last_in   = 1'b0;
                     rsp_count_in  = remain[tmeb_pkg::COUNT_OUT_BITS-1:0];
                  end
                  held_in       = rd_data_ff;
                  held_valid_in = 1'b1;
                  taken_in      = taken_ff + 1'b1;
               end else begin
                  // compact kept entry toward the old end
                  mem_we    = 1'b1;
                  mem_waddr = keep_ff[AW-1:0];
                  mem_wdata = rd_data_ff;
                  keep_in   = keep_ff + 1'b1;
               end
            end else if (issue_ff == count_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (held_valid_ff) begin
                  rsp_status_in = tmeb_pkg::STATUS_OK;
                  rsp_entry_in  = held_ff;
                  rsp_count_in  = remain[tmeb_pkg::COUNT_OUT_BITS-1:0];
                  count_in      = CW'(remain);
                  held_valid_in = 1'b0;
               end else begin
                  rsp_status_in = tmeb_pkg::STATUS_NONE_FOUND;
                  rsp_entry_in  = '0;
                  rsp_count_in  = tmeb_pkg::COUNT_OUT_BITS'(TW'(count_ff));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_valid_ff  <= chk_valid_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      issue_ff      <= issue_in;
      keep_ff       <= keep_in;
      taken_ff      <= taken_in;
      held_ff       <= held_in;
      kind_ff       <= kind_in;
      tag_ff        <= tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_status   = rsp_status_ff;
   assign rsp_out_receiver    = rsp_entry_ff[PAYLOAD_BITS + 2*tmeb_pkg::TAG_BITS +: tmeb_pkg::TAG_BITS];
   assign rsp_out_transmitter = rsp_entry_ff[PAYLOAD_BITS + tmeb_pkg::TAG_BITS +: tmeb_pkg::TAG_BITS];
   assign rsp_out_target      = rsp_entry_ff[PAYLOAD_BITS +: tmeb_pkg::TAG_BITS];
   assign rsp_out_payload     = rsp_entry_ff[PAYLOAD_BITS-1:0];
   assign rsp_last_of_run     = rsp_last_ff;
   assign rsp_stored_count    = rsp_count_ff;

   // an insert always answers in the next cycle with a final result
   a_insert_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == tmeb_pkg::CMD_INSERT) |=> (rsp_valid && rsp_last_of_run))
      else $error("insert did not answer in the next cycle");

   // full and none found results close the run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_status != tmeb_pkg::STATUS_OK) |-> rsp_last_of_run)
      else $error("non entry result without last mark");

   // count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH))
      else $error("entry count beyond depth");

   // compaction writes never overtake the scan reads
   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (keep_ff <= issue_ff))
      else $error("compaction pointer ahead of scan");

endmodule

/* tb/tmeb_checker.sv */
// tmeb_checker.sv: predicts and checks the results of the tag match extract buffer
`timescale 1ns / 1ps

module tmeb_checker #(
   parameter int STORE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_cmd,
   input  logic [tmeb_pkg::KIND_BITS-1:0]      req_tag_kind,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       req_tag_value,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       req_entry_receiver,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       req_entry_transmitter,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       req_entry_target,
   input  logic [PAYLOAD_BITS-1:0]             req_entry_payload,
   input  logic                                rsp_valid,
   input  logic [tmeb_pkg::STATUS_BITS-1:0]    rsp_result_status,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       rsp_out_receiver,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       rsp_out_transmitter,
   input  logic [tmeb_pkg::TAG_BITS-1:0]       rsp_out_target,
   input  logic [PAYLOAD_BITS-1:0]             rsp_out_payload,
   input  logic                                rsp_last_of_run,
   input  logic [tmeb_pkg::COUNT_OUT_BITS-1:0] rsp_stored_count,
   output int                                  mismatch_count,
   output int                                  due_count
);
   import tmeb_pkg::*;

   typedef struct {
      logic [STATUS_BITS-1:0]    status;
      tags_type                  tags;
      logic [PAYLOAD_BITS-1:0]   body;
      logic                      last;
      logic [COUNT_OUT_BITS-1:0] count;
   } entry_result_type;

   // shadow copy of the entry store
   tags_type                held_tags [STORE_DEPTH];
   logic [PAYLOAD_BITS-1:0] held_body [STORE_DEPTH];
   int                      held_count;
   entry_result_type        due_results [$];

   function automatic logic key_hit(tags_type t, logic [KIND_BITS-1:0] kind,
                                    logic [TAG_BITS-1:0] value);
      if (kind == KIND_RECEIVER) return t.receiver == value;
      if (kind == KIND_TRANSMITTER) return t.transmitter == value;
      if (kind == KIND_TARGET) return t.target == value;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   task automatic push_result(input logic [STATUS_BITS-1:0] status, input tags_type tags,
                              input logic [PAYLOAD_BITS-1:0] body, input logic last);
      entry_result_type r;
      r.status = status;
      r.tags   = tags;
      r.body   = body;
      r.last   = last;
      r.count  = held_count[COUNT_OUT_BITS-1:0];
      due_results.insert(due_results.size(), r);
   endtask

   task automatic apply_item();
      tags_type                taken_tags [$];
      logic [PAYLOAD_BITS-1:0] taken_body [$];
      int                      keep;
      int                      n;
      if (req_cmd == CMD_INSERT) begin
         if (held_count >= STORE_DEPTH) begin
            push_result(STATUS_FULL, '0, '0, 1'b1);
         end else begin
            held_tags[held_count] = '{receiver: req_entry_receiver,
                                      transmitter: req_entry_transmitter,
                                      target: req_entry_target};
            held_body[held_count] = req_entry_payload;
            held_count++;
            push_result(STATUS_OK, '0, '0, 1'b1);
         end
      end else begin
         keep = 0;
         for (int i = 0; i < held_count; i++) begin
            if (taken_tags.size() < MAX_RESULTS &&
                key_hit(held_tags[i], req_tag_kind, req_tag_value)) begin
               taken_tags.insert(taken_tags.size(), held_tags[i]);
               taken_body.insert(taken_body.size(), held_body[i]);
            end else begin
               // survivors slide toward the old end in order
               held_tags[keep] = held_tags[i];
               held_body[keep] = held_body[i];
               keep++;
            end
         end
         n = taken_tags.size();
         if (n == 0) begin
            push_result(STATUS_NONE_FOUND, '0, '0, 1'b1);
         end else begin
            held_count = keep + n;
            for (int k = 0; k < n; k++) begin
               held_count--;
               push_result(STATUS_OK, taken_tags[k], taken_body[k], k == n - 1);
            end
         end
      end
   endtask

   task automatic check_result();
      entry_result_type e;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result with none due, status %0d", rsp_result_status));
      end else begin
         e = due_results.pop_front();
         if (rsp_result_status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_result_status, e.status));
         if (rsp_out_receiver !== e.tags.receiver)
            report_mismatch($sformatf("receiver %h, want %h", rsp_out_receiver,
                                      e.tags.receiver));
         if (rsp_out_transmitter !== e.tags.transmitter)
            report_mismatch($sformatf("transmitter %h, want %h", rsp_out_transmitter,
                                      e.tags.transmitter));
         if (rsp_out_target !== e.tags.target)
            report_mismatch($sformatf("target %h, want %h", rsp_out_target, e.tags.target));
         if (rsp_out_payload !== e.body)
            report_mismatch($sformatf("payload %h, want %h", rsp_out_payload, e.body));
         if (rsp_last_of_run !== e.last)
            report_mismatch($sformatf("last %b, want %b", rsp_last_of_run, e.last));
         if (rsp_stored_count !== e.count)
            report_mismatch($sformatf("count %0d, want %0d", rsp_stored_count, e.count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count     = 0;
         mismatch_count = 0;
         due_results.delete();
      end else begin
         // results of earlier items come before the item taken at this edge
         if (rsp_valid) check_result();
         if (start && !busy) apply_item();
      end
      due_count <= due_results.size();
   end

endmodule

/* tb/tb_top.sv */
// tb_top.sv: stimulus, watchdog and verdict for the tag match extract buffer
`timescale 1ns / 1ps

module tb_top;
   import tmeb_pkg::*;

   localparam int STORE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_cmd;
   logic [KIND_BITS-1:0]      req_tag_kind;
   logic [TAG_BITS-1:0]       req_tag_value;
   logic [TAG_BITS-1:0]       req_entry_receiver;
   logic [TAG_BITS-1:0]       req_entry_transmitter;
   logic [TAG_BITS-1:0]       req_entry_target;
   logic [PAYLOAD_BITS-1:0]   req_entry_payload;
   logic                      rsp_valid;
   logic [STATUS_BITS-1:0]    rsp_result_status;
   logic [TAG_BITS-1:0]       rsp_out_receiver;
   logic [TAG_BITS-1:0]       rsp_out_transmitter;
   logic [TAG_BITS-1:0]       rsp_out_target;
   logic [PAYLOAD_BITS-1:0]   rsp_out_payload;
   logic                      rsp_last_of_run;
   logic [COUNT_OUT_BITS-1:0] rsp_stored_count;
   int                        mismatch_count;
   int                        due_count;
   int                        stalled_cycles;

   // tags drawn from a small set so pops find matches
   logic [TAG_BITS-1:0] common_tags [4] = '{8'h00, 8'hff, 8'h5a, 8'h81};
   int                  pool_size;
   int                  common_pct;

   tag_match_extract_buffer_top #(
      .STORE_DEPTH (STORE_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_tag_kind         (req_tag_kind),
      .req_tag_value        (req_tag_value),
      .req_entry_receiver   (req_entry_receiver),
      .req_entry_transmitter(req_entry_transmitter),
      .req_entry_target     (req_entry_target),
      .req_entry_payload    (req_entry_payload),
      .rsp_valid            (rsp_valid),
      .rsp_result_status    (rsp_result_status),
      .rsp_out_receiver     (rsp_out_receiver),
      .rsp_out_transmitter  (rsp_out_transmitter),
      .rsp_out_target       (rsp_out_target),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_stored_count     (rsp_stored_count)
   );

   tmeb_checker #(
      .STORE_DEPTH (STORE_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_tag_kind         (req_tag_kind),
      .req_tag_value        (req_tag_value),
      .req_entry_receiver   (req_entry_receiver),
      .req_entry_transmitter(req_entry_transmitter),
      .req_entry_target     (req_entry_target),
      .req_entry_payload    (req_entry_payload),
      .rsp_valid            (rsp_valid),
      .rsp_result_status    (rsp_result_status),
      .rsp_out_receiver     (rsp_out_receiver),
      .rsp_out_transmitter  (rsp_out_transmitter),
      .rsp_out_target       (rsp_out_target),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_stored_count     (rsp_stored_count),
      .mismatch_count       (mismatch_count),
      .due_count            (due_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   function automatic logic [TAG_BITS-1:0] pick_tag();
      if ($urandom_range(0, 99) < common_pct) return common_tags[$urandom_range(0, pool_size - 1)];
      return TAG_BITS'($urandom);
   endfunction

   function automatic tags_type pick_tags();
      tags_type t;
      t.receiver    = pick_tag();
      t.transmitter = pick_tag();
      t.target      = pick_tag();
      return t;
   endfunction

   function automatic logic [KIND_BITS-1:0] pick_kind();
      if ($urandom_range(0, 9) == 0) return KIND_UNUSED;
      case ($urandom_range(0, 2))
         0:       return KIND_RECEIVER;
         1:       return KIND_TRANSMITTER;
         default: return KIND_TARGET;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one item and return at the edge that takes it
   task automatic issue(input logic cmd, input logic [KIND_BITS-1:0] kind,
                        input logic [TAG_BITS-1:0] value, input tags_type tags,
                        input logic [PAYLOAD_BITS-1:0] body);
      req_cmd               <= cmd;
      req_tag_kind          <= kind;
      req_tag_value         <= value;
      req_entry_receiver    <= tags.receiver;
      req_entry_transmitter <= tags.transmitter;
      req_entry_target      <= tags.target;
      req_entry_payload     <= body;
      start                 <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   initial begin
      tags_type                t;
      logic [PAYLOAD_BITS-1:0] body;
      int                      insert_pct;
      bit                      quiet;
      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_cmd               <= CMD_INSERT;
      req_tag_kind          <= KIND_RECEIVER;
      req_tag_value         <= '0;
      req_entry_receiver    <= '0;
      req_entry_transmitter <= '0;
      req_entry_target      <= '0;
      req_entry_payload     <= '0;
      pool_size  = 4;
      common_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // pop on an empty store
      issue(CMD_POP, KIND_TARGET, 8'hff, pick_tags(), $urandom);
      // fill to depth: adjacent receiver matches at the old end,
      // adjacent transmitter matches at the young end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         t.receiver    = (i < 3) ? 8'h00 : TAG_BITS'(8'h80 + i);
         t.transmitter = (i >= STORE_DEPTH - 3) ? 8'hff : TAG_BITS'(8'h40 + i);
         t.target      = 8'h5a;
         case (i % 3)
            0:       body = '0;
            1:       body = '1;
            default: body = $urandom;
         endcase
         issue(CMD_INSERT, pick_kind(), TAG_BITS'($urandom), t, body);
      end
      issue(CMD_INSERT, KIND_TARGET, 8'h5a, '{8'hff, 8'hff, 8'hff}, '1);
      issue(CMD_POP, KIND_UNUSED, 8'h5a, pick_tags(), $urandom);
      issue(CMD_POP, KIND_RECEIVER, 8'h00, pick_tags(), $urandom);
      issue(CMD_POP, KIND_TRANSMITTER, 8'hff, pick_tags(), $urandom);
      issue(CMD_POP, KIND_RECEIVER, 8'h87, pick_tags(), $urandom);
      issue(CMD_POP, KIND_TARGET, 8'h5a, pick_tags(), $urandom);
      wait_for_results();

      // random phases with varying insert weight and tag spread
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 30;
            1:       insert_pct = 55;
            default: insert_pct = 80;
         endcase
         pool_size  = $urandom_range(1, 4);
         common_pct = $urandom_range(0, 1) ? 100 : 70;
         quiet      = ($urandom_range(0, 3) == 0);
         for (int j = 0; j < 50; j++) begin
            if ($urandom_range(0, 99) < insert_pct)
               issue(CMD_INSERT, pick_kind(), TAG_BITS'($urandom), pick_tags(), $urandom);
            else
               issue(CMD_POP, pick_kind(), pick_tag(), pick_tags(), $urandom);
            if ($urandom_range(0, 49) == 0)
               wait_for_results();
            else if (!quiet)
               hold_off(pick_gap());
         end
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

/* tag_match_extract_buffer_top.f */
sv/tmeb_pkg.sv
sv/tag_match_extract_buffer_top.sv
tb/tmeb_checker.sv
tb/tb_top.sv
